/* hdl/cdwp_pkg.sv */
// ----------------------------------------------------------------------------
// CRC data write packer package
// Shared beat types, command encoding and constants for the write packer.
// ----------------------------------------------------------------------------
package cdwp_pkg;

   // Configuration port geometry and register indexes
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 8;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODULE_ENABLE = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DATA_WIDTH_REG = 2'd1;

   // Data length register and its decision points
   localparam int LEN_WIDTH = 6;
   localparam logic [LEN_WIDTH-1:0] LEN_RESET = 6'd8;
   localparam logic [LEN_WIDTH-1:0] LEN_BYTE  = 6'd8;
   localparam logic [LEN_WIDTH-1:0] LEN_HALF  = 6'd16;
   localparam logic [LEN_WIDTH-1:0] LEN_TRI   = 6'd24;

   // Access width codes
   localparam logic [1:0] ACCESS_BYTE = 2'd1;
   localparam logic [1:0] ACCESS_WORD = 2'd2;

   // Latch lane masks
   localparam logic [31:0] MASK_LO_WORD = 32'h0000_ffff;
   localparam logic [31:0] MASK_LANE1   = 32'h0000_ff00;
   localparam logic [31:0] MASK_LANE0   = 32'h0000_00ff;
   localparam logic [31:0] MASK_HI_WORD = 32'hffff_0000;
   localparam logic [31:0] MASK_LANE3   = 32'hff00_0000;
   localparam logic [31:0] MASK_LANE2   = 32'h00ff_0000;

   // Command queue geometry (depth is a power of two)
   localparam int QUEUE_DEPTH       = 2;
   localparam int QUEUE_PTR_WIDTH   = 1;
   localparam int QUEUE_COUNT_WIDTH = 2;

   // Input beat
   typedef struct packed {
      logic [1:0]  register_offset;
      logic [1:0]  write_bytes;
      logic [15:0] data_word;
   } req_type;

   // Result beat
   typedef struct packed {
      logic        push_valid;
      logic [31:0] push_value;
   } rsp_type;

   // Work for the back end
   typedef enum logic [2:0] {
      OP_NONE        = 3'd0,
      OP_PUSH_DIRECT = 3'd1,
      OP_PUSH_CLEAR  = 3'd2,
      OP_LOAD        = 3'd3,
      OP_LOAD_PUSH   = 3'd4
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] mask;
      logic [31:0] data;
   } cmd_type;

endpackage

/* hdl/cdwp_front.sv */
// ----------------------------------------------------------------------------
// CRC data write packer front end
// Holds the configuration registers, accepts write beats and classifies
// each one into a command for the back end.
// ----------------------------------------------------------------------------
module cdwp_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [cdwp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [cdwp_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  cdwp_pkg::req_type                    req_data,
   output logic                                 cmd_valid,
   input  logic                                 cmd_ready,
   output cdwp_pkg::cmd_type                    cmd_data
);
   import cdwp_pkg::*;

   logic                 enable_ff, enable_in;
   logic [LEN_WIDTH-1:0] len_ff, len_in;
   logic                 upper, hi_lane;
   logic [1:0]           bytes;
   logic [15:0]          word;

   // Configuration writes, always taken
   assign csr_ready = 1'b1;

   always_comb begin
      enable_in = enable_ff;
      len_in    = len_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MODULE_ENABLE:  enable_in = csr_data[0];
            CSR_DATA_WIDTH_REG: len_in    = csr_data[LEN_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         len_ff    <= LEN_RESET;
      end else begin
         enable_ff <= enable_in;
         len_ff    <= len_in;
      end
   end

   // Handshake passes straight to the queue
   assign cmd_valid = req_valid;
   assign req_stall = !cmd_ready;

   assign upper   = req_data.register_offset[1];
   assign hi_lane = req_data.register_offset[0];
   assign bytes   = req_data.write_bytes;
   assign word    = req_data.data_word;

   // Classify the write
   always_comb begin
      cmd_data.op   = OP_NONE;
      cmd_data.mask = '0;
      cmd_data.data = '0;
      if (!enable_ff) begin
         cmd_data.op = OP_NONE;
      end else if (len_ff <= LEN_BYTE) begin
         // short length: every write pushes
         cmd_data.op = OP_PUSH_DIRECT;
         if (bytes == ACCESS_BYTE) begin
            cmd_data.data = hi_lane ? {24'd0, word[15:8]} : {24'd0, word[7:0]};
         end else begin
            cmd_data.data = {16'd0, word};
         end
      end else if (!upper) begin
         if (len_ff <= LEN_HALF) begin
            if (bytes == ACCESS_WORD) begin
               cmd_data.op   = OP_PUSH_CLEAR;
               cmd_data.data = {16'd0, word};
            end
         end else begin
            // low half of a long value
            cmd_data.op = OP_LOAD;
            if (bytes == ACCESS_WORD) begin
               cmd_data.mask = MASK_LO_WORD;
            end else if (hi_lane) begin
               cmd_data.mask = MASK_LANE1;
            end else begin
               cmd_data.mask = MASK_LANE0;
            end
            cmd_data.data = {16'd0, word} & cmd_data.mask;
         end
      end else if (len_ff > LEN_HALF) begin
         // high half: push when the configured length is complete
         if (bytes == ACCESS_WORD) begin
            cmd_data.op   = OP_LOAD_PUSH;
            cmd_data.mask = MASK_HI_WORD;
         end else if (hi_lane) begin
            cmd_data.op   = (len_ff > LEN_TRI) ? OP_LOAD_PUSH : OP_LOAD;
            cmd_data.mask = MASK_LANE3;
         end else begin
            cmd_data.op   = (len_ff <= LEN_TRI) ? OP_LOAD_PUSH : OP_LOAD;
            cmd_data.mask = MASK_LANE2;
         end
         cmd_data.data = {word, 16'd0} & cmd_data.mask;
      end
   end

endmodule

/* hdl/cdwp_queue.sv */
// ----------------------------------------------------------------------------
// CRC data write packer command queue
// Short register queue between the front and back ends.
// ----------------------------------------------------------------------------
module cdwp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  cdwp_pkg::cmd_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output cdwp_pkg::cmd_type pop_data
);
   import cdwp_pkg::*;

   cmd_type                      entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_WIDTH-1:0] count_ff, count_in;
   logic                         wr_en, rd_en;

   assign push_ready = (count_ff != QUEUE_COUNT_WIDTH'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entries_ff[rd_ptr_ff];

   assign wr_en = push_valid && push_ready;
   assign rd_en = pop_valid && pop_ready;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_en ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = rd_en ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hdl/cdwp_back.sv */
// ----------------------------------------------------------------------------
// CRC data write packer back end
// Applies commands to the assembly latch and registers the result beat.
// ----------------------------------------------------------------------------
module cdwp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  cdwp_pkg::cmd_type cmd_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cdwp_pkg::rsp_type rsp_data
);
   import cdwp_pkg::*;

   logic [31:0] latch_ff, latch_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;
   logic [31:0] merged;
   logic        take;

   // Output register free or draining this cycle
   assign cmd_ready = !rsp_valid_ff || !rsp_stall;
   assign take      = cmd_valid && cmd_ready;

   assign merged = (latch_ff & ~cmd_data.mask) | cmd_data.data;

   // Latch update and result
   always_comb begin
      latch_in    = latch_ff;
      rsp_data_in = rsp_data_ff;
      if (take) begin
         rsp_data_in = '0;
         case (cmd_data.op)
            OP_PUSH_DIRECT: begin
               rsp_data_in.push_valid = 1'b1;
               rsp_data_in.push_value = cmd_data.data;
            end
            OP_PUSH_CLEAR: begin
               rsp_data_in.push_valid = 1'b1;
               rsp_data_in.push_value = cmd_data.data;
               latch_in               = '0;
            end
            OP_LOAD: begin
               latch_in = merged;
            end
            OP_LOAD_PUSH: begin
               rsp_data_in.push_valid = 1'b1;
               rsp_data_in.push_value = merged;
               latch_in               = '0;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         latch_ff     <= latch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* hdl/crc_data_write_packer_core.sv */
// ----------------------------------------------------------------------------
// CRC data write packer core
// Turns byte and word writes to the two CRC data words into engine pushes.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one beat per data write (offset, access width, 16-bit data).
//   rsp_*  : exactly one beat per write; push_valid marks a value for the
//            CRC engine, push_value is zero when nothing is pushed.
//   csr_*  : register writes (0 = module enable, 1 = data length), always
//            ready; write only while no write beat is in flight.
//   An accepted beat goes into the command queue, is taken from it by the
//   back end into the result register and shows on rsp. Throughput: one
//   beat per cycle while rsp_stall is low, set by the back end latch update.
//   A two-entry command queue sits between the classifier and the latch,
//   so req keeps flowing while a finished result waits on rsp_stall; req
//   stalls only once the queue is full.
//   Reset: module disabled, length 8, assembly latch cleared, queue and
//   output emptied.
// ----------------------------------------------------------------------------
module crc_data_write_packer_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [cdwp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [cdwp_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  cdwp_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output cdwp_pkg::rsp_type                    rsp_data
);
   import cdwp_pkg::*;

   logic    fq_valid, fq_ready;
   cmd_type fq_data;
   logic    qb_valid, qb_ready;
   cmd_type qb_data;

   // Classifier
   cdwp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (fq_valid),
      .cmd_ready (fq_ready),
      .cmd_data  (fq_data)
   );

   // Command queue
   cdwp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_data),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_data   (qb_data)
   );

   // Latch and result register
   cdwp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (qb_valid),
      .cmd_ready (qb_ready),
      .cmd_data  (qb_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* hdl/cdwp_checker.sv */
// ----------------------------------------------------------------------------
// CRC data write packer port checker
// Watches the top-level ports for result and flow-control consistency.
// ----------------------------------------------------------------------------
module cdwp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input cdwp_pkg::rsp_type rsp_data
);
   import cdwp_pkg::*;

   // A beat without a push carries a zero value
   a_no_push_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.push_valid |-> rsp_data.push_value == 32'd0)
      else $error("non-push beat carries a value");

   // A stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

   // Reset empties the block
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not empty after reset");

   // With no result pending the queue cannot be full
   a_idle_accepts: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output");

endmodule

bind crc_data_write_packer_core cdwp_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
